FILE: src/ptc_pkg.sv
// Shared constants, types and class codes of the pressure trend classifier.
`default_nettype none
package ptc_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int SHORT_WINDOW  = 10;
    localparam int LONG_WINDOW   = 60;

    localparam int PRESS_W = 17;
    localparam int DIFF_W  = PRESS_W + 1;
    localparam int DROP_W  = 11;
    localparam int RISE_W  = 10;
    localparam int CONF_W  = 4;
    localparam int CLASS_W = 3;
    localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // A window longer than the history never fills.
    localparam bit SHORT_ON = (SHORT_WINDOW <= HISTORY_DEPTH);
    localparam bit LONG_ON  = (LONG_WINDOW <= HISTORY_DEPTH);

    // Cell k of the chain holds the sample k + 1 steps back.
    localparam int SHORT_TAP = SHORT_ON ? SHORT_WINDOW - 2 : 0;
    localparam int LONG_TAP  = LONG_ON ? LONG_WINDOW - 2 : 0;
    localparam int CHAIN_LEN = ((SHORT_TAP > LONG_TAP) ? SHORT_TAP : LONG_TAP) + 1;

    localparam logic [CLASS_W-1:0] CLS_INVALID  = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_THUNDER  = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_RAIN     = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_SUNNY    = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_OVERCAST = 3'd4;

    localparam logic [2:0] REG_FAST_DROP_SHORT = 3'd0;
    localparam logic [2:0] REG_SLOW_DROP_SHORT = 3'd1;
    localparam logic [2:0] REG_DROP_LONG       = 3'd2;
    localparam logic [2:0] REG_RISE_SHORT      = 3'd3;
    localparam logic [2:0] REG_RISE_LONG       = 3'd4;
    localparam logic [2:0] REG_CONFIRM_COUNT   = 3'd5;

    typedef struct packed {
        logic signed [DROP_W-1:0] fast_drop_short;
        logic signed [DROP_W-1:0] slow_drop_short;
        logic signed [DROP_W-1:0] drop_long;
        logic        [RISE_W-1:0] rise_short;
        logic        [RISE_W-1:0] rise_long;
        logic        [CONF_W-1:0] confirm_count;
    } ptc_cfg_t;

    typedef struct packed {
        logic               step;
        logic               window_full;
        logic [CLASS_W-1:0] cand;
    } ptc_vote_t;

endpackage
`default_nettype wire

FILE: src/pressure_trend_classifier.sv
// Top level of the pressure trend classifier: history chain, registers and output stage.
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      s_pressure_pa (17 bits, pascal)
//  m_        out        m_valid / m_ready      m_prediction, m_candidate_now (3 bits each)
//  APB       in/out     psel/penable/pready    six threshold and count registers
//
//  Each accepted word is classified in the cycle it is accepted and its result word is
//  shown in the next cycle, so one word per cycle is sustained while m_ready stays high.
//  The rate is set by the single output stage: the debounce registers are the payload,
//  and a new word is taken whenever that stage is empty or being emptied.
//  A synchronous low aresetn clears the counters, the classes and the output valid;
//  the history cells are not reset, since a cell is only read after it has been filled.
//  While a result word waits for m_ready, s_ready is low and the history does not move.
`default_nettype none
module pressure_trend_classifier (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [ptc_pkg::PRESS_W-1:0]   s_pressure_pa,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [ptc_pkg::CLASS_W-1:0]   m_prediction,
    output logic [ptc_pkg::CLASS_W-1:0]   m_candidate_now,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [ptc_pkg::APB_AW-1:0]    paddr,
    input  wire  [ptc_pkg::APB_DW-1:0]    pwdata,
    output logic [ptc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import ptc_pkg::*;

    logic               accept;
    logic               cfg_we;
    ptc_cfg_t           cfg_reg, cfg_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    logic               short_full;
    logic               long_full;
    logic [CLASS_W-1:0] cand;
    ptc_vote_t          vote;
    logic [PRESS_W-1:0] chain_q [CHAIN_LEN];

    assign accept = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // Configuration port. Writes complete in the access phase; pready is tied high.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (paddr[4:2])
                REG_FAST_DROP_SHORT: cfg_next.fast_drop_short = pwdata[DROP_W-1:0];
                REG_SLOW_DROP_SHORT: cfg_next.slow_drop_short = pwdata[DROP_W-1:0];
                REG_DROP_LONG:       cfg_next.drop_long       = pwdata[DROP_W-1:0];
                REG_RISE_SHORT:      cfg_next.rise_short      = pwdata[RISE_W-1:0];
                REG_RISE_LONG:       cfg_next.rise_long       = pwdata[RISE_W-1:0];
                REG_CONFIRM_COUNT:   cfg_next.confirm_count   = pwdata[CONF_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data: the signed thresholds are returned sign extended.
    always_comb begin
        unique case (paddr[4:2])
            REG_FAST_DROP_SHORT: prdata = APB_DW'(cfg_reg.fast_drop_short);
            REG_SLOW_DROP_SHORT: prdata = APB_DW'(cfg_reg.slow_drop_short);
            REG_DROP_LONG:       prdata = APB_DW'(cfg_reg.drop_long);
            REG_RISE_SHORT:      prdata = {{(APB_DW-RISE_W){1'b0}}, cfg_reg.rise_short};
            REG_RISE_LONG:       prdata = {{(APB_DW-RISE_W){1'b0}}, cfg_reg.rise_long};
            REG_CONFIRM_COUNT:   prdata = {{(APB_DW-CONF_W){1'b0}}, cfg_reg.confirm_count};
            default:             prdata = '0;
        endcase
    end

    // The sample count saturates at the history depth.
    always_comb begin
        count_next = count_reg;
        if (accept && count_reg < COUNT_W'(HISTORY_DEPTH)) begin
            count_next = count_reg + 1'b1;
        end
    end

    assign short_full = SHORT_ON && (count_next >= COUNT_W'(SHORT_WINDOW));
    assign long_full  = LONG_ON && (count_next >= COUNT_W'(LONG_WINDOW));

    // The history chain: cell 0 takes the incoming sample, each further cell takes
    // the one before it, so cell k holds the sample k + 1 words back.
    genvar gi;
    generate
        for (gi = 0; gi < CHAIN_LEN; gi++) begin : g_chain
            if (gi == 0) begin : g_head
                ptc_cell u_cell (
                    .aclk  (aclk),
                    .shift (accept),
                    .d     (s_pressure_pa),
                    .q     (chain_q[gi])
                );
            end else begin : g_body
                ptc_cell u_cell (
                    .aclk  (aclk),
                    .shift (accept),
                    .d     (chain_q[gi-1]),
                    .q     (chain_q[gi])
                );
            end
        end
    endgenerate

    ptc_classify u_classify (
        .pressure  (s_pressure_pa),
        .short_old (chain_q[SHORT_TAP]),
        .long_old  (chain_q[LONG_TAP]),
        .long_full (long_full),
        .cfg       (cfg_reg),
        .cand      (cand)
    );

    assign vote.step        = accept;
    assign vote.window_full = short_full;
    assign vote.cand        = cand;

    ptc_debounce u_debounce (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .vote          (vote),
        .confirm_count (cfg_reg.confirm_count),
        .prediction    (m_prediction),
        .candidate     (m_candidate_now)
    );

    // The output stage fills on an accepted word and empties when the word is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_drop_short <= -11'sd100;
            cfg_reg.slow_drop_short <= -11'sd30;
            cfg_reg.drop_long       <= -11'sd150;
            cfg_reg.rise_short      <= 10'd50;
            cfg_reg.rise_long       <= 10'd150;
            cfg_reg.confirm_count   <= 4'd3;
            count_reg               <= '0;
            m_valid_reg             <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted word did not produce a result word");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while a result word is stalled");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(HISTORY_DEPTH))
        else $error("sample count ran past the history depth");

    a_invalid_before_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (!SHORT_ON || count_reg < COUNT_W'(SHORT_WINDOW))
            |-> (m_prediction == CLS_INVALID && m_candidate_now == CLS_INVALID))
        else $error("class reported before the short window filled");

endmodule
`default_nettype wire

FILE: src/ptc_cell.sv
// One stage of the sample history chain.
`default_nettype none
module ptc_cell (
    input  wire                          aclk,
    input  wire                          shift,
    input  wire  [ptc_pkg::PRESS_W-1:0]  d,
    output logic [ptc_pkg::PRESS_W-1:0]  q
);
    import ptc_pkg::*;

    logic [PRESS_W-1:0] sample_reg;
    logic [PRESS_W-1:0] sample_next;

    // The sample moves one cell further on with every accepted word.
    assign sample_next = shift ? d : sample_reg;

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
    end

    assign q = sample_reg;

endmodule
`default_nettype wire

FILE: src/ptc_classify.sv
// Window differences and the threshold rules that pick a candidate class.
`default_nettype none
module ptc_classify (
    input  wire  [ptc_pkg::PRESS_W-1:0]  pressure,
    input  wire  [ptc_pkg::PRESS_W-1:0]  short_old,
    input  wire  [ptc_pkg::PRESS_W-1:0]  long_old,
    input  wire                          long_full,
    input  wire  ptc_pkg::ptc_cfg_t      cfg,
    output logic [ptc_pkg::CLASS_W-1:0]  cand
);
    import ptc_pkg::*;

    logic signed [DIFF_W-1:0] d_short;
    logic signed [DIFF_W-1:0] d_long;
    logic signed [DIFF_W-1:0] t_fast;
    logic signed [DIFF_W-1:0] t_slow;
    logic signed [DIFF_W-1:0] t_drop;
    logic signed [DIFF_W-1:0] t_rise_s;
    logic signed [DIFF_W-1:0] t_rise_l;

    always_comb begin
        d_short  = $signed({1'b0, pressure}) - $signed({1'b0, short_old});
        d_long   = long_full ? ($signed({1'b0, pressure}) - $signed({1'b0, long_old}))
                             : '0;
        t_fast   = DIFF_W'(cfg.fast_drop_short);
        t_slow   = DIFF_W'(cfg.slow_drop_short);
        t_drop   = DIFF_W'(cfg.drop_long);
        t_rise_s = $signed({{(DIFF_W-RISE_W){1'b0}}, cfg.rise_short});
        t_rise_l = $signed({{(DIFF_W-RISE_W){1'b0}}, cfg.rise_long});

        if (d_short <= t_fast) begin
            cand = CLS_THUNDER;
        end else if (d_short <= t_slow || d_long <= t_drop) begin
            cand = CLS_RAIN;
        end else if (d_short >= t_rise_s || d_long >= t_rise_l) begin
            cand = CLS_SUNNY;
        end else begin
            cand = CLS_OVERCAST;
        end
    end

endmodule
`default_nettype wire

FILE: src/ptc_debounce.sv
// Candidate, confirmation counter and committed class.
`default_nettype none
module ptc_debounce (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  ptc_pkg::ptc_vote_t     vote,
    input  wire  [ptc_pkg::CONF_W-1:0]   confirm_count,
    output logic [ptc_pkg::CLASS_W-1:0]  prediction,
    output logic [ptc_pkg::CLASS_W-1:0]  candidate
);
    import ptc_pkg::*;

    logic [CLASS_W-1:0] cand_reg,   cand_next;
    logic [CLASS_W-1:0] commit_reg, commit_next;
    logic [CONF_W-1:0]  cnt_reg,    cnt_next;

    always_comb begin
        cand_next   = cand_reg;
        commit_next = commit_reg;
        cnt_next    = cnt_reg;
        if (vote.step) begin
            if (!vote.window_full) begin
                cand_next   = CLS_INVALID;
                commit_next = CLS_INVALID;
                cnt_next    = '0;
            end else if (vote.cand == cand_reg) begin
                if (cnt_reg < confirm_count) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (cnt_next >= confirm_count) begin
                    commit_next = cand_reg;
                end
            end else begin
                cand_next = vote.cand;
                cnt_next  = CONF_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg   <= CLS_INVALID;
            commit_reg <= CLS_INVALID;
            cnt_reg    <= '0;
        end else begin
            cand_reg   <= cand_next;
            commit_reg <= commit_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign prediction = commit_reg;
    assign candidate  = cand_reg;

endmodule
`default_nettype wire
